// ===== rtl/core/utrf_pkg.sv =====
// Shared constants, function codes and control types for the UART ring queues.
`default_nettype none
package utrf_pkg;

  localparam int unsigned TX_DEPTH = 512;
  localparam int unsigned RX_DEPTH = 256;
  localparam int unsigned TX_PW    = $clog2(TX_DEPTH);
  localparam int unsigned RX_PW    = $clog2(RX_DEPTH);

  localparam logic [2:0] FUNC_WRITE  = 3'd0;
  localparam logic [2:0] FUNC_READY  = 3'd1;
  localparam logic [2:0] FUNC_RXBYTE = 3'd2;
  localparam logic [2:0] FUNC_READ   = 3'd3;
  localparam logic [2:0] FUNC_FLUSH  = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/core/utrf_ctrl.sv =====
// Handshake controller: sequences capture, execute and result hand-off.
`default_nettype none
module utrf_ctrl
  import utrf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_RESP) && out_ready_i);
  assign out_valid_o = (state_q == ST_RESP);
  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign cmd_o.exec  = (state_q == ST_EXEC);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) state_d = in_valid_i ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule
`default_nettype wire

// ===== rtl/core/utrf_dp.sv =====
// Datapath: transmit and receive rings, pointers, busy flag and result registers.
`default_nettype none
module utrf_dp
  import utrf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  input  wire logic [2:0] func_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_in_batch_i,
  output logic            accepted_o,
  output logic            tx_start_o,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            tx_stop_o,
  output logic            rx_valid_o,
  output logic [7:0]      rx_byte_o,
  output logic            rx_dropped_o,
  output logic [7:0]      rx_count_o,
  output logic            busy_res_o
);

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];

  // captured transaction
  logic [2:0] func_q;
  logic [7:0] byte_q;
  logic       last_q;

  logic [TX_PW-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d;
  logic [RX_PW-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d;
  logic             busy_q, busy_d, batch_q, batch_d;

  logic acc_q, acc_d, start_q, start_d, txv_q, txv_d, stop_q, stop_d;
  logic rxv_q, rxv_d, drop_q, drop_d;
  logic [7:0] tx_data_q, rx_data_q;

  logic tx_full, tx_empty, rx_empty, rx_wrap;
  logic tx_we, rx_we, tx_re, rx_re;
  logic [RX_PW-1:0] rx_lvl;

  assign tx_full  = (tx_wr_q + TX_PW'(1)) == tx_rd_q;
  assign tx_empty = (tx_wr_q == tx_rd_q);
  assign rx_empty = (rx_wr_q == rx_rd_q);
  assign rx_wrap  = (rx_wr_q + RX_PW'(1)) == rx_rd_q;

  always_comb begin
    tx_wr_d = tx_wr_q;
    tx_rd_d = tx_rd_q;
    rx_wr_d = rx_wr_q;
    rx_rd_d = rx_rd_q;
    busy_d  = busy_q;
    batch_d = batch_q;
    acc_d   = 1'b0;
    start_d = 1'b0;
    txv_d   = 1'b0;
    stop_d  = 1'b0;
    rxv_d   = 1'b0;
    drop_d  = 1'b0;
    tx_we   = 1'b0;
    rx_we   = 1'b0;
    tx_re   = 1'b0;
    rx_re   = 1'b0;
    case (func_q)
      FUNC_WRITE: begin
        if (!tx_full) begin
          tx_we   = 1'b1;
          tx_wr_d = tx_wr_q + TX_PW'(1);
          acc_d   = 1'b1;
          batch_d = 1'b1;
        end
        if (last_q) begin
          if (batch_d && !busy_q) begin
            busy_d  = 1'b1;
            start_d = 1'b1;
          end
          batch_d = 1'b0;
        end
      end
      FUNC_READY: begin
        if (!tx_empty) begin
          tx_re   = 1'b1;
          tx_rd_d = tx_rd_q + TX_PW'(1);
          txv_d   = 1'b1;
        end else begin
          busy_d = 1'b0;
          stop_d = 1'b1;
        end
      end
      FUNC_RXBYTE: begin
        // overwrite the oldest byte when full
        if (rx_wrap) begin
          rx_rd_d = rx_rd_q + RX_PW'(1);
          drop_d  = 1'b1;
        end
        rx_we   = 1'b1;
        rx_wr_d = rx_wr_q + RX_PW'(1);
      end
      FUNC_READ: begin
        if (!rx_empty) begin
          rx_re   = 1'b1;
          rx_rd_d = rx_rd_q + RX_PW'(1);
          rxv_d   = 1'b1;
        end
      end
      FUNC_FLUSH: begin
        rx_rd_d = rx_wr_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      byte_q <= data_byte_i;
      last_q <= last_in_batch_i;
    end
    if (cmd_i.exec) begin
      acc_q   <= acc_d;
      start_q <= start_d;
      txv_q   <= txv_d;
      stop_q  <= stop_d;
      rxv_q   <= rxv_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && tx_we) tx_mem[tx_wr_q] <= byte_q;
    if (cmd_i.exec && tx_re) tx_data_q <= tx_mem[tx_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && rx_we) rx_mem[rx_wr_q] <= byte_q;
    if (cmd_i.exec && rx_re) rx_data_q <= rx_mem[rx_rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wr_q <= '0;
      tx_rd_q <= '0;
      rx_wr_q <= '0;
      rx_rd_q <= '0;
      busy_q  <= 1'b0;
      batch_q <= 1'b0;
    end else if (cmd_i.exec) begin
      tx_wr_q <= tx_wr_d;
      tx_rd_q <= tx_rd_d;
      rx_wr_q <= rx_wr_d;
      rx_rd_q <= rx_rd_d;
      busy_q  <= busy_d;
      batch_q <= batch_d;
    end
  end

  assign rx_lvl = rx_wr_q - rx_rd_q;

  assign accepted_o   = acc_q;
  assign tx_start_o   = start_q;
  assign tx_valid_o   = txv_q;
  assign tx_byte_o    = txv_q ? tx_data_q : 8'h00;
  assign tx_stop_o    = stop_q;
  assign rx_valid_o   = rxv_q;
  assign rx_byte_o    = rxv_q ? rx_data_q : 8'h00;
  assign rx_dropped_o = drop_q;
  assign rx_count_o   = (rx_lvl > RX_PW'(255)) ? 8'hFF : 8'(rx_lvl);
  assign busy_res_o   = busy_q;

  a_tx_push_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (func_q == FUNC_WRITE) && !tx_full |=> tx_wr_q == $past(tx_wr_q) + TX_PW'(1))
    else $error("transmit write pointer did not advance on push");

  a_rx_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (func_q == FUNC_RXBYTE) |=> rx_wr_q != rx_rd_q)
    else $error("receive ring empty after line byte");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> !(start_q && !busy_q) && !(start_q && stop_q))
    else $error("transmit start without busy, or with stop");

endmodule
`default_nettype wire

// ===== rtl/core/uart_tx_rx_ring_fifo.sv =====
// Top level: UART transmit and receive ring queues with valid/ready channels.
// Timing: after a transaction is accepted the controller passes through the
//   execute state and then the result state, where out_valid is raised.
// Flow: a new item is accepted only in idle, or in the result state when the
//   result is taken; the registered read port of each ring memory sets the execute step.
// Reset clears all pointers, the busy flag and the batch flag at once; ring
//   contents are not cleared and no clearing pass runs.
`default_nettype none
module uart_tx_rx_ring_fifo
  import utrf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] func_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_in_batch_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            accepted_o,
  output logic            tx_start_o,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            tx_stop_o,
  output logic            rx_valid_o,
  output logic [7:0]      rx_byte_o,
  output logic            rx_dropped_o,
  output logic [7:0]      rx_count_o,
  output logic            busy_res_o
);

  cmd_t cmd;

  utrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  utrf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (func_i),
    .data_byte_i     (data_byte_i),
    .last_in_batch_i (last_in_batch_i),
    .accepted_o      (accepted_o),
    .tx_start_o      (tx_start_o),
    .tx_valid_o      (tx_valid_o),
    .tx_byte_o       (tx_byte_o),
    .tx_stop_o       (tx_stop_o),
    .rx_valid_o      (rx_valid_o),
    .rx_byte_o       (rx_byte_o),
    .rx_dropped_o    (rx_dropped_o),
    .rx_count_o      (rx_count_o),
    .busy_res_o      (busy_res_o)
  );

endmodule
`default_nettype wire

// ===== verif/uart_tx_rx_ring_fifo_tb.sv =====
// Self-checking testbench for the UART transmit and receive ring queues.
`timescale 1ns / 100ps
module uart_tx_rx_ring_fifo_tb;
  import utrf_pkg::*;

  localparam logic [2:0] FUNC_SPARE5 = 3'd5;
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 10;

  typedef struct packed {
    logic       accepted;
    logic       tx_start;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_stop;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_dropped;
    logic [7:0] rx_count;
    logic       busy;
  } queue_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [2:0] func = FUNC_WRITE;
  logic [7:0] data_byte = 8'h00;
  logic       last_in_batch = 1'b0;
  logic       out_ready = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic       accepted;
  logic       tx_start;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       tx_stop;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       rx_dropped;
  logic [7:0] rx_count;
  logic       busy_res;

  // Shadow copy of both rings and the transmit flags
  logic [7:0]       tx_mem [TX_DEPTH];
  logic [TX_PW-1:0] tx_wr = '0;
  logic [TX_PW-1:0] tx_rd = '0;
  logic [7:0]       rx_mem [RX_DEPTH];
  logic [RX_PW-1:0] rx_wr = '0;
  logic [RX_PW-1:0] rx_rd = '0;
  logic             busy_flag = 1'b0;
  logic             batch_hit = 1'b0;

  queue_result_t results_due[$];
  int err_cnt = 0;
  int tx_refused_cnt = 0;
  int rx_drop_cnt = 0;
  int in_idle_pct = 13;
  int out_idle_pct = 13;

  uart_tx_rx_ring_fifo uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func),
    .data_byte_i     (data_byte),
    .last_in_batch_i (last_in_batch),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .accepted_o      (accepted),
    .tx_start_o      (tx_start),
    .tx_valid_o      (tx_valid),
    .tx_byte_o       (tx_byte),
    .tx_stop_o       (tx_stop),
    .rx_valid_o      (rx_valid),
    .rx_byte_o       (rx_byte),
    .rx_dropped_o    (rx_dropped),
    .rx_count_o      (rx_count),
    .busy_res_o      (busy_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic compute_queue_result(input logic [2:0] f, input logic [7:0] d,
                                      input logic l);
    queue_result_t r;
    logic [TX_PW-1:0] tx_nxt;
    logic [RX_PW-1:0] rx_nxt;
    int unsigned rx_lvl;
    r = '0;
    tx_nxt = tx_wr + 1'b1;
    rx_nxt = rx_wr + 1'b1;
    case (f)
      FUNC_WRITE: begin
        if (tx_nxt != tx_rd) begin
          tx_mem[tx_wr] = d;
          tx_wr = tx_nxt;
          r.accepted = 1'b1;
          batch_hit = 1'b1;
        end else begin
          tx_refused_cnt++;
        end
        // Batch end check runs even when this byte was refused
        if (l) begin
          if (batch_hit && !busy_flag) begin
            busy_flag = 1'b1;
            r.tx_start = 1'b1;
          end
          batch_hit = 1'b0;
        end
      end
      FUNC_READY: begin
        if (tx_wr != tx_rd) begin
          r.tx_byte = tx_mem[tx_rd];
          r.tx_valid = 1'b1;
          tx_rd = tx_rd + 1'b1;
        end else begin
          busy_flag = 1'b0;
          r.tx_stop = 1'b1;
        end
      end
      FUNC_RXBYTE: begin
        // Full ring: overwrite the oldest byte
        if (rx_nxt == rx_rd) begin
          rx_rd = rx_rd + 1'b1;
          r.rx_dropped = 1'b1;
          rx_drop_cnt++;
        end
        rx_mem[rx_wr] = d;
        rx_wr = rx_nxt;
      end
      FUNC_READ: begin
        if (rx_wr != rx_rd) begin
          r.rx_byte = rx_mem[rx_rd];
          r.rx_valid = 1'b1;
          rx_rd = rx_rd + 1'b1;
        end
      end
      FUNC_FLUSH: rx_rd = rx_wr;
      default: ;
    endcase
    rx_lvl = RX_PW'(rx_wr - rx_rd);
    r.rx_count = (rx_lvl > 255) ? 8'hFF : 8'(rx_lvl);
    r.busy = busy_flag;
    results_due.push_back(r);
  endtask

  // Hold valid across back-to-back transactions; drop it only for an idle gap
  task automatic send_item(input logic [2:0] f, input logic [7:0] d, input logic l);
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    func <= f;
    data_byte <= d;
    last_in_batch <= l;
    do @(posedge clk); while (!in_ready);
    compute_queue_result(f, d, l);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  task automatic test_tx_basics();
    send_item(FUNC_READY, 8'h00, 1'b0);
    send_item(FUNC_WRITE, 8'h00, 1'b0);
    send_item(FUNC_WRITE, 8'hFF, 1'b1);
    send_item(FUNC_WRITE, 8'hA5, 1'b1);
    repeat (3) send_item(FUNC_READY, 8'hFF, 1'b1);
    send_item(FUNC_READY, 8'h00, 1'b0);
    send_item(FUNC_WRITE, 8'h3C, 1'b1);
    send_item(FUNC_READY, 8'h00, 1'b0);
    send_item(FUNC_READY, 8'h00, 1'b0);
    // A write that does not end its batch is accepted but must not start
    send_item(FUNC_WRITE, 8'h81, 1'b0);
    send_item(FUNC_READY, 8'h00, 1'b0);
    send_item(FUNC_READY, 8'h00, 1'b0);
  endtask

  task automatic test_rx_basics();
    send_item(FUNC_READ, 8'h00, 1'b0);
    send_item(FUNC_RXBYTE, 8'h00, 1'b0);
    send_item(FUNC_RXBYTE, 8'hFF, 1'b1);
    send_item(FUNC_RXBYTE, 8'h5A, 1'b0);
    send_item(FUNC_READ, 8'hFF, 1'b1);
    send_item(FUNC_FLUSH, 8'h00, 1'b0);
    send_item(FUNC_READ, 8'h00, 1'b0);
    send_item(FUNC_SPARE5, 8'hFF, 1'b1);
    send_item(FUNC_SPARE6, 8'hFF, 1'b1);
    send_item(FUNC_SPARE7, 8'hFF, 1'b1);
  endtask

  // Push both rings past full so refusals and overwrites occur
  task automatic test_fill_queues();
    int unsigned roll;
    while (tx_refused_cnt < 6 || rx_drop_cnt < 6) begin
      roll = $urandom_range(99);
      if (roll < 66)
        send_item(FUNC_WRITE, rand_byte(), $urandom_range(4) == 0);
      else if (roll < 98)
        send_item(FUNC_RXBYTE, rand_byte(), 1'($urandom_range(1)));
      else if (roll < 99)
        send_item(FUNC_READY, rand_byte(), 1'($urandom_range(1)));
      else
        send_item(FUNC_READ, rand_byte(), 1'($urandom_range(1)));
    end
  endtask

  // Pop a stretch of bytes from the full transmit ring
  task automatic test_drain_tx();
    int unsigned roll;
    for (int i = 0; i < 40 && tx_wr != tx_rd; i++) begin
      roll = $urandom_range(99);
      if (roll < 85)
        send_item(FUNC_READY, rand_byte(), 1'($urandom_range(1)));
      else if (roll < 95)
        send_item(FUNC_READ, rand_byte(), 1'($urandom_range(1)));
      else
        send_item(FUNC_RXBYTE, rand_byte(), 1'($urandom_range(1)));
    end
    repeat (3) send_item(FUNC_READY, rand_byte(), 1'b1);
  endtask

  task automatic test_mixed_traffic();
    int unsigned roll;
    logic [2:0] f;
    for (int i = 0; i < 80; i++) begin
      // First half runs at full rate on both sides
      in_idle_pct = (i < 40) ? 0 : 13;
      out_idle_pct = (i < 40) ? 0 : 13;
      roll = $urandom_range(99);
      if (roll < 28)      f = FUNC_WRITE;
      else if (roll < 52) f = FUNC_READY;
      else if (roll < 72) f = FUNC_RXBYTE;
      else if (roll < 87) f = FUNC_READ;
      else if (roll < 91) f = FUNC_FLUSH;
      else begin
        case ($urandom_range(2))
          0:       f = FUNC_SPARE5;
          1:       f = FUNC_SPARE6;
          default: f = FUNC_SPARE7;
        endcase
      end
      send_item(f, rand_byte(), $urandom_range(2) == 0);
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t got;
    out_ready <= (out_idle_pct == 0) || ($urandom_range(99) >= out_idle_pct);
    if (out_valid && out_ready) begin
      got = {accepted, tx_start, tx_valid, tx_byte, tx_stop, rx_valid, rx_byte,
             rx_dropped, rx_count, busy_res};
      if (results_due.size() == 0) begin
        $display("%0t: result with none expected, actual %0h", $time, got);
        err_cnt++;
      end else begin
        want = results_due.pop_front();
        check_field("accepted", want.accepted, got.accepted);
        check_field("tx_start", want.tx_start, got.tx_start);
        check_field("tx_valid", want.tx_valid, got.tx_valid);
        check_field("tx_byte", want.tx_byte, got.tx_byte);
        check_field("tx_stop", want.tx_stop, got.tx_stop);
        check_field("rx_valid", want.rx_valid, got.rx_valid);
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("rx_dropped", want.rx_dropped, got.rx_dropped);
        check_field("rx_count", want.rx_count, got.rx_count);
        check_field("busy_res", want.busy, got.busy);
      end
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_tx_basics();
    wait_drained();
    test_rx_basics();
    wait_drained();
    test_fill_queues();
    wait_drained();
    test_drain_tx();
    wait_drained();
    test_mixed_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== uart_tx_rx_ring_fifo.f =====
rtl/core/utrf_pkg.sv
rtl/core/utrf_ctrl.sv
rtl/core/utrf_dp.sv
rtl/core/uart_tx_rx_ring_fifo.sv
verif/uart_tx_rx_ring_fifo_tb.sv
